/* rtl/core/lrvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrvc_pkg
// Shared types and constants of the label region vote classifier.
// ----------------------------------------------------------------------------
package lrvc_pkg;

  localparam int unsigned LABEL_W        = 11;
  localparam int unsigned COUNT_W        = 17;
  localparam int unsigned ENTRY_W        = 2 * COUNT_W;
  localparam int unsigned FRAC_W         = 9;
  localparam int unsigned FRAC_SH        = 8;
  localparam int unsigned MAX_LABELS_DEF = 1024;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [FRAC_W-1:0]  FRAC_ONE  = 9'd256;
  localparam logic [FRAC_W-1:0]  FRAC_RST  = 9'd128;

  typedef enum logic [1:0] {
    MODE_ACC   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic acc_wr;
    logic load_res;
    logic sweep_wr;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  in_valid;
    mode_t in_mode;
    mode_t cur_mode;
    logic  sweep_last;
    logic  res_busy;
  } dp_stat_t;

endpackage

/* rtl/core/lrvc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrvc_if
// Valid/ready channels of the classifier: pixel/query input, result, config.
// ----------------------------------------------------------------------------
interface lrvc_pix_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic signed [10:0]    label;
  logic                  inside_req;

  modport source (output valid, mode, label, inside_req, input ready);
  modport sink   (input valid, mode, label, inside_req, output ready);
endinterface

interface lrvc_res_if;
  logic valid;
  logic ready;
  logic include_bit;
  logic exclude_bit;

  modport source (output valid, include_bit, exclude_bit, input ready);
  modport sink   (input valid, include_bit, exclude_bit, output ready);
endinterface

interface lrvc_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] include_fraction;

  modport source (output valid, include_fraction, input ready);
  modport sink   (input valid, include_fraction, output ready);
endinterface

/* rtl/core/lrvc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lrvc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrvc_ctrl
// Sequencer: clearing sweep, item capture, count update or result load.
// ----------------------------------------------------------------------------
module lrvc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  lrvc_pkg::dp_stat_t stat,
  output lrvc_pkg::dp_cmd_t  cmd,
  output logic               in_ready
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (stat.sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (stat.in_valid) begin
            unique case (stat.in_mode)
              lrvc_pkg::MODE_ACC,
              lrvc_pkg::MODE_QUERY: state <= S_EXEC;
              lrvc_pkg::MODE_CLEAR: state <= S_SWEEP;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_EXEC: begin
          // a query waits here while the previous result is still held
          if (stat.cur_mode != lrvc_pkg::MODE_QUERY || !stat.res_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_SWEEP;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    in_ready     = (state == S_IDLE);
    cmd.capture  = (state == S_IDLE) && stat.in_valid;
    cmd.sweep_wr = (state == S_SWEEP);
    cmd.acc_wr   = (state == S_EXEC) && (stat.cur_mode == lrvc_pkg::MODE_ACC);
    cmd.load_res = (state == S_EXEC) && (stat.cur_mode == lrvc_pkg::MODE_QUERY)
                   && !stat.res_busy;
  end

endmodule

/* rtl/core/lrvc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrvc_dp
// Count memory, saturating update, vote compare, result and config registers.
// ----------------------------------------------------------------------------
module lrvc_dp #(
  parameter int unsigned MAX_LABELS = lrvc_pkg::MAX_LABELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lrvc_pkg::dp_cmd_t  cmd,
  output lrvc_pkg::dp_stat_t stat,
  lrvc_pix_if.sink           pix,
  lrvc_res_if.source         res,
  lrvc_cfg_if.sink           cfg
);

  localparam int unsigned IW   = $clog2(MAX_LABELS);
  localparam int unsigned CW   = lrvc_pkg::COUNT_W;
  localparam int unsigned PW   = lrvc_pkg::COUNT_W + lrvc_pkg::FRAC_W;
  localparam int unsigned EW   = lrvc_pkg::ENTRY_W;
  localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_LABELS - 1);

  logic [lrvc_pkg::FRAC_W-1:0] frac;
  lrvc_pkg::mode_t             cur_mode;
  logic                        cur_ok;
  logic                        cur_inside;
  logic [IW-1:0]               cur_addr;
  logic [IW-1:0]               sweep_addr;
  logic                        res_valid;
  logic                        res_inc;
  logic                        res_exc;

  logic [31:0]   lbl_ext;
  logic          in_ok;
  logic [IW-1:0] in_addr;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic [CW-1:0] tot;
  logic [CW-1:0] inr;
  logic [CW-1:0] outr;
  logic [CW-1:0] tot_inc;
  logic [CW-1:0] inr_inc;
  logic [lrvc_pkg::FRAC_W-1:0] f_eff;
  logic [lrvc_pkg::FRAC_W-1:0] f_rest;
  logic [PW-1:0] lhs_in;
  logic [PW-1:0] rhs_in;
  logic [PW-1:0] lhs_out;
  logic [PW-1:0] rhs_out;
  logic          vote_inc;
  logic          vote_exc;

  // noise labels have the sign bit set
  assign lbl_ext = {22'd0, pix.label[9:0]};
  assign in_ok   = !pix.label[10] && (lbl_ext < 32'(MAX_LABELS));
  assign in_addr = lbl_ext[IW-1:0];

  assign tot  = ram_rdata[EW-1:CW];
  assign inr  = ram_rdata[CW-1:0];
  assign outr = tot - inr;

  assign tot_inc = tot + CW'(1);
  assign inr_inc = (cur_inside && inr != lrvc_pkg::COUNT_MAX) ? inr + CW'(1) : inr;

  always_comb begin
    f_eff   = (frac > lrvc_pkg::FRAC_ONE) ? lrvc_pkg::FRAC_ONE : frac;
    f_rest  = lrvc_pkg::FRAC_ONE - f_eff;
    lhs_in  = PW'({inr, 8'd0});
    lhs_out = PW'({outr, 8'd0});
    rhs_in  = PW'(f_eff) * PW'(tot);
    rhs_out = PW'(f_rest) * PW'(tot);
    vote_inc = cur_ok && (tot != '0) && (lhs_in >= rhs_in);
    vote_exc = cur_ok && (tot != '0) && !vote_inc && (lhs_out >= rhs_out);
  end

  always_comb begin
    if (cmd.sweep_wr) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.acc_wr && cur_ok && (tot != lrvc_pkg::COUNT_MAX);
      ram_waddr = cur_addr;
      ram_wdata = {tot_inc, inr_inc};
    end
  end

  lrvc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_LABELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frac       <= lrvc_pkg::FRAC_RST;
      sweep_addr <= '0;
      res_valid  <= 1'b0;
      cur_mode   <= lrvc_pkg::MODE_NONE;
    end else begin
      if (cfg.valid) begin
        frac <= cfg.include_fraction;
      end
      if (cmd.sweep_wr) begin
        sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + IW'(1);
      end
      if (cmd.capture) begin
        cur_mode <= lrvc_pkg::mode_t'(pix.mode);
      end
      if (cmd.load_res) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_ok     <= in_ok;
      cur_inside <= pix.inside_req;
      cur_addr   <= in_addr;
    end
    if (cmd.load_res) begin
      res_inc <= vote_inc;
      res_exc <= vote_exc;
    end
  end

  assign cfg.ready       = 1'b1;
  assign res.valid       = res_valid;
  assign res.include_bit = res_inc;
  assign res.exclude_bit = res_exc;

  assign stat.in_valid   = pix.valid;
  assign stat.in_mode    = lrvc_pkg::mode_t'(pix.mode);
  assign stat.cur_mode   = cur_mode;
  assign stat.sweep_last = (sweep_addr == LAST_ADDR);
  assign stat.res_busy   = res_valid && !res.ready;

endmodule

/* rtl/core/label_region_vote_classifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_region_vote_classifier_core
// Per-label pixel counting and inside/outside region vote for label queries.
// ----------------------------------------------------------------------------
// channels: pix takes one item per transaction (mode 0 accumulates a pixel,
//   mode 1 queries a label, mode 2 clears all counts, mode 3 is ignored);
//   res returns include_bit/exclude_bit, one transaction per query only;
//   cfg writes include_fraction (Q1.8, values above 256 act as 256), always
//   ready, to be written only while no item is in flight.
// timing: an accumulate or query is captured in S_IDLE; in S_EXEC the registered
//   read of the count RAM feeds the read-modify-write or vote, and a query
//   result goes into the result register. Mode 3 leaves the sequencer in S_IDLE.
// clearing: after reset, and after every clear item, pix.ready stays low
//   while the count RAM is swept one entry per cycle.
// stall: the result register holds while res.ready is low; further pixels
//   keep being accepted, and a following query waits in S_EXEC
//   until the held result has gone.
// ----------------------------------------------------------------------------
module label_region_vote_classifier_core #(
  parameter int unsigned MAX_LABELS = lrvc_pkg::MAX_LABELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lrvc_pix_if.sink   pix,
  lrvc_res_if.source res,
  lrvc_cfg_if.sink   cfg
);

  lrvc_pkg::dp_cmd_t  cmd;
  lrvc_pkg::dp_stat_t stat;

  lrvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (pix.ready)
  );

  lrvc_dp #(
    .MAX_LABELS (MAX_LABELS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .pix  (pix),
    .res  (res),
    .cfg  (cfg)
  );

endmodule

/* rtl/core/lrvc_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrvc_chk
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module lrvc_chk (
  input logic       clk,
  input logic       rst,
  input logic       pix_valid,
  input logic       pix_ready,
  input logic [1:0] pix_mode,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_inc,
  input logic       res_exc
);

  // a label is never both included and excluded
  a_vote_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_inc && res_exc))
    else $error("include and exclude both set");

  // held result stays put while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_inc) && $stable(res_exc))
    else $error("result changed under stall");

  // the clearing sweep blocks input right after reset
  a_sweep_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !pix_ready)
    else $error("input accepted during clearing sweep");

  // one item at a time: a working item drops ready for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && (pix_mode != lrvc_pkg::MODE_NONE) |=> !pix_ready)
    else $error("second item accepted while one is in progress");

endmodule

bind label_region_vote_classifier_core lrvc_chk u_lrvc_chk (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_mode  (pix.mode),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_inc   (res.include_bit),
  .res_exc   (res.exclude_bit)
);
